/* rtl/lmwa_pkg.sv */
`default_nettype none

package lmwa_pkg;

   // Load samples and averages are per-mille values
   localparam int LOAD_W   = 10;
   localparam int LOAD_MAX = 1000;

   // Request codes
   localparam logic [1:0] REQ_RECORD = 2'd0;
   localparam logic [1:0] REQ_TICK   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [LOAD_W-1:0] sample;
   } req_item_type;

   typedef struct packed {
      logic [LOAD_W-1:0] avg_short;
      logic [LOAD_W-1:0] avg_medium;
      logic [LOAD_W-1:0] avg_long;
      logic              sample_dropped;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DIV,
      ST_APPEND,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      JOB_SHORT,
      JOB_MEDIUM,
      JOB_LONG
   } job_type;

endpackage

`default_nettype wire

/* rtl/load_multi_window_average.sv */
// Record, clear and no-op requests go straight to the response state.
// A minute tick forms the one-minute average (zero if no samples were held), appends it,
// then forms the medium and long averages for any window that it closes.
// One request at a time, accepted in the cycle after the previous response is loaded;
// sums stream through the memory read port, averages share one bit-serial divider.
// Synchronous reset clears counts and averages; stores are not cleared.
`default_nettype none

module load_multi_window_average #(
   parameter int SAMPLES_PER_PERIOD = 12,
   parameter int MEDIUM_WINDOW      = 5,
   parameter int LONG_WINDOW        = 30
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lmwa_pkg::req_item_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lmwa_pkg::rsp_item_type      rsp_data
);

   localparam int LW     = lmwa_pkg::LOAD_W;
   localparam int MAX_AB = (SAMPLES_PER_PERIOD > MEDIUM_WINDOW) ?
                           SAMPLES_PER_PERIOD : MEDIUM_WINDOW;
   localparam int MAXN   = (MAX_AB > LONG_WINDOW) ? MAX_AB : LONG_WINDOW;
   localparam int CNT_W  = $clog2(MAXN + 1);
   localparam int SUM_W  = $clog2(MAXN * lmwa_pkg::LOAD_MAX + 1);
   localparam int SC_W   = $clog2(SAMPLES_PER_PERIOD + 1);
   localparam int SA_W   = (SAMPLES_PER_PERIOD > 1) ? $clog2(SAMPLES_PER_PERIOD) : 1;
   localparam int MC_W   = $clog2(LONG_WINDOW + 1);
   localparam int MA_W   = $clog2(LONG_WINDOW);
   localparam int RA_W   = (SA_W > MA_W) ? SA_W : MA_W;
   localparam int PH_W   = (MEDIUM_WINDOW > 1) ? $clog2(MEDIUM_WINDOW) : 1;

   // Control and state registers
   lmwa_pkg::state_type state_ff, state_in;
   logic [SC_W-1:0]     scount_ff, scount_in;
   logic [MC_W-1:0]     mcount_ff, mcount_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                med_due_ff, med_due_in;
   logic [LW-1:0]       short_ff, short_in;
   logic [LW-1:0]       medium_ff, medium_in;
   logic [LW-1:0]       long_ff, long_in;
   logic                pend_ff, pend_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   lmwa_pkg::job_type      job_ff, job_in;
   logic [RA_W-1:0]        rd_addr_ff, rd_addr_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic [CNT_W-1:0]       den_ff, den_in;
   logic                   drop_ff, drop_in;
   lmwa_pkg::rsp_item_type rsp_data_ff, rsp_data_in;

   // Memory and divider hookup
   logic             s_we;
   logic [LW-1:0]    s_wdata;
   logic [LW-1:0]    s_rdata;
   logic             m_we;
   logic [LW-1:0]    m_rdata;
   logic [LW-1:0]    rd_word;
   logic             div_start;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;
   logic [LW-1:0]    quo_short;

   logic req_fire;
   logic rsp_free;
   logic sum_end;
   logic long_due;
   logic s_full;

   assign req_stall = (state_ff != lmwa_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign sum_end   = (state_ff == lmwa_pkg::ST_SUM) && (left_ff == '0) && !pend_ff;
   assign long_due  = (mcount_ff == MC_W'(LONG_WINDOW));
   assign s_full    = (scount_ff == SC_W'(SAMPLES_PER_PERIOD));
   assign div_start = sum_end;
   assign quo_short = div_quo[LW-1:0];
   assign rd_word   = (job_ff == lmwa_pkg::JOB_SHORT) ? s_rdata : m_rdata;

   // Saturate the incoming sample
   assign s_wdata = (req_data.sample > LW'(lmwa_pkg::LOAD_MAX)) ?
                    LW'(lmwa_pkg::LOAD_MAX) : req_data.sample;

   lmwa_ram #(
      .WIDTH (LW),
      .DEPTH (SAMPLES_PER_PERIOD)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (scount_ff[SA_W-1:0]),
      .wr_data (s_wdata),
      .rd_addr (rd_addr_ff[SA_W-1:0]),
      .rd_data (s_rdata)
   );

   lmwa_ram #(
      .WIDTH (LW),
      .DEPTH (LONG_WINDOW)
   ) u_minute_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (mcount_ff[MA_W-1:0]),
      .wr_data (short_ff),
      .rd_addr (rd_addr_ff[MA_W-1:0]),
      .rd_data (m_rdata)
   );

   lmwa_div #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmwa_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.req_type == lmwa_pkg::REQ_TICK) begin
                  state_in = (scount_ff != '0) ? lmwa_pkg::ST_SUM : lmwa_pkg::ST_APPEND;
               end else begin
                  state_in = lmwa_pkg::ST_RESP;
               end
            end
         end
         lmwa_pkg::ST_SUM: begin
            if (sum_end) begin
               state_in = lmwa_pkg::ST_DIV;
            end
         end
         lmwa_pkg::ST_DIV: begin
            if (div_done) begin
               case (job_ff)
                  lmwa_pkg::JOB_SHORT:  state_in = lmwa_pkg::ST_APPEND;
                  lmwa_pkg::JOB_MEDIUM: state_in = long_due ? lmwa_pkg::ST_SUM
                                                            : lmwa_pkg::ST_RESP;
                  default:              state_in = lmwa_pkg::ST_RESP;
               endcase
            end
         end
         lmwa_pkg::ST_APPEND: state_in = lmwa_pkg::ST_CHECK;
         lmwa_pkg::ST_CHECK: begin
            state_in = (med_due_ff || long_due) ? lmwa_pkg::ST_SUM : lmwa_pkg::ST_RESP;
         end
         lmwa_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = lmwa_pkg::ST_IDLE;
            end
         end
         default: state_in = lmwa_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      scount_in    = scount_ff;
      mcount_in    = mcount_ff;
      phase_in     = phase_ff;
      med_due_in   = med_due_ff;
      short_in     = short_ff;
      medium_in    = medium_ff;
      long_in      = long_ff;
      pend_in      = pend_ff;
      left_in      = left_ff;
      job_in       = job_ff;
      rd_addr_in   = rd_addr_ff;
      acc_in       = acc_ff;
      den_in       = den_ff;
      drop_in      = drop_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      s_we         = 1'b0;
      m_we         = 1'b0;

      case (state_ff)
         lmwa_pkg::ST_IDLE: begin
            if (req_fire) begin
               drop_in = 1'b0;
               case (req_data.req_type)
                  lmwa_pkg::REQ_RECORD: begin
                     if (s_full) begin
                        drop_in = 1'b1;
                     end else begin
                        s_we      = 1'b1;
                        scount_in = scount_ff + SC_W'(1);
                     end
                  end
                  lmwa_pkg::REQ_TICK: begin
                     // Empty the sample store and sum what it held
                     scount_in  = '0;
                     job_in     = lmwa_pkg::JOB_SHORT;
                     rd_addr_in = '0;
                     left_in    = CNT_W'(scount_ff);
                     den_in     = CNT_W'(scount_ff);
                     acc_in     = '0;
                     pend_in    = 1'b0;
                     if (scount_ff == '0) begin
                        short_in = '0;
                     end
                  end
                  lmwa_pkg::REQ_CLEAR: begin
                     scount_in  = '0;
                     mcount_in  = '0;
                     phase_in   = '0;
                     med_due_in = 1'b0;
                     short_in   = '0;
                     medium_in  = '0;
                     long_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         lmwa_pkg::ST_SUM: begin
            // Stream entries through the read port and accumulate
            pend_in = (left_ff != '0);
            if (left_ff != '0) begin
               rd_addr_in = rd_addr_ff + RA_W'(1);
               left_in    = left_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               acc_in = acc_ff + SUM_W'(rd_word);
            end
         end
         lmwa_pkg::ST_DIV: begin
            if (div_done) begin
               case (job_ff)
                  lmwa_pkg::JOB_SHORT: short_in = quo_short;
                  lmwa_pkg::JOB_MEDIUM: begin
                     medium_in = quo_short;
                     if (long_due) begin
                        job_in     = lmwa_pkg::JOB_LONG;
                        rd_addr_in = '0;
                        left_in    = CNT_W'(LONG_WINDOW);
                        den_in     = CNT_W'(LONG_WINDOW);
                        acc_in     = '0;
                        pend_in    = 1'b0;
                     end
                  end
                  default: begin
                     // Long window closed: empty the minute store
                     long_in   = quo_short;
                     mcount_in = '0;
                     phase_in  = '0;
                  end
               endcase
            end
         end
         lmwa_pkg::ST_APPEND: begin
            // Append the one-minute value and advance the window phase
            m_we       = 1'b1;
            mcount_in  = mcount_ff + MC_W'(1);
            med_due_in = (phase_ff == PH_W'(MEDIUM_WINDOW - 1));
            phase_in   = (phase_ff == PH_W'(MEDIUM_WINDOW - 1)) ? '0 : phase_ff + PH_W'(1);
         end
         lmwa_pkg::ST_CHECK: begin
            med_due_in = 1'b0;
            acc_in     = '0;
            pend_in    = 1'b0;
            if (med_due_ff) begin
               job_in     = lmwa_pkg::JOB_MEDIUM;
               rd_addr_in = RA_W'(mcount_ff - MC_W'(MEDIUM_WINDOW));
               left_in    = CNT_W'(MEDIUM_WINDOW);
               den_in     = CNT_W'(MEDIUM_WINDOW);
            end else begin
               job_in     = lmwa_pkg::JOB_LONG;
               rd_addr_in = '0;
               left_in    = CNT_W'(LONG_WINDOW);
               den_in     = CNT_W'(LONG_WINDOW);
            end
         end
         lmwa_pkg::ST_RESP: begin
            // Load the response register once it is free
            if (rsp_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.avg_short      = short_ff;
               rsp_data_in.avg_medium     = medium_ff;
               rsp_data_in.avg_long       = long_ff;
               rsp_data_in.sample_dropped = drop_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lmwa_pkg::ST_IDLE;
         scount_ff    <= '0;
         mcount_ff    <= '0;
         phase_ff     <= '0;
         med_due_ff   <= 1'b0;
         short_ff     <= '0;
         medium_ff    <= '0;
         long_ff      <= '0;
         pend_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scount_ff    <= scount_in;
         mcount_ff    <= mcount_in;
         phase_ff     <= phase_in;
         med_due_ff   <= med_due_in;
         short_ff     <= short_in;
         medium_ff    <= medium_in;
         long_ff      <= long_in;
         pend_ff      <= pend_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rd_addr_ff  <= rd_addr_in;
      acc_ff      <= acc_in;
      den_ff      <= den_in;
      drop_ff     <= drop_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sample count never passes the store depth
   assert property (@(posedge clock) disable iff (reset)
      scount_ff <= SC_W'(SAMPLES_PER_PERIOD))
      else $error("sample count beyond store depth");

   // Minute store is never full between requests
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == lmwa_pkg::ST_IDLE) |-> (mcount_ff < MC_W'(LONG_WINDOW)))
      else $error("minute count not wrapped at long window");

   // Divider never starts on a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> (den_ff != '0))
      else $error("divide by zero started");

   // Divider result only arrives while waiting for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == lmwa_pkg::ST_DIV))
      else $error("divider done outside wait state");

endmodule

`default_nettype wire

/* rtl/lmwa_ram.sv */
`default_nettype none

module lmwa_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/lmwa_div.sv */
`default_nettype none

module lmwa_div #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   shifted;
   logic             fits;
   logic [DEN_W:0]   rem_in;
   logic [NUM_W-1:0] quo_in;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      rem_in  = fits ? (shifted - {1'b0, den_ff}) : shifted;
      quo_in  = {quo_ff[NUM_W-2:0], fits};
   end

   // Step control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* verif/load_multi_window_average_tb.sv */
`timescale 1ns / 100ps

module load_multi_window_average_tb;

   localparam int SAMPLE_SLOTS   = 12;
   localparam int MEDIUM_SPAN    = 5;
   localparam int LONG_SPAN      = 30;
   localparam int RANDOM_ITEMS   = 880;
   localparam int DRAIN_CYCLES   = 150;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct {
      lmwa_pkg::req_item_type request;
      bit                     typed;
      lmwa_pkg::rsp_item_type answer;
   } directed_row_type;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   lmwa_pkg::req_item_type req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   lmwa_pkg::rsp_item_type rsp_data;

   // predictor state
   logic [lmwa_pkg::LOAD_W-1:0] sample_buf [SAMPLE_SLOTS];
   int unsigned                 sample_fill;
   logic [lmwa_pkg::LOAD_W-1:0] minute_buf [LONG_SPAN];
   int unsigned                 minute_fill;
   logic [lmwa_pkg::LOAD_W-1:0] one_min_avg;
   logic [lmwa_pkg::LOAD_W-1:0] five_min_avg;
   logic [lmwa_pkg::LOAD_W-1:0] thirty_min_avg;

   lmwa_pkg::rsp_item_type expected_loads [$];
   directed_row_type       directed_table [$];
   lmwa_pkg::rsp_item_type oldest_load;

   int unsigned cycle_count      = 0;
   int unsigned mismatch_count   = 0;
   int unsigned responses_seen   = 0;
   int unsigned records_sent     = 0;
   int unsigned ticks_sent       = 0;
   int unsigned clears_sent      = 0;
   int unsigned unused_sent      = 0;
   int unsigned samples_dropped  = 0;
   int unsigned medium_closed    = 0;
   int unsigned long_closed      = 0;
   int unsigned calm_requests    = 0;
   int unsigned stall_hold       = 0;
   int unsigned stall_roll;
   bit          stall_now        = 1'b0;

   load_multi_window_average i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5;
      clock = 1'b1;
      #5;
      clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void clear_load_history();
      sample_fill    = 0;
      minute_fill    = 0;
      one_min_avg    = '0;
      five_min_avg   = '0;
      thirty_min_avg = '0;
   endfunction

   // Advance the averaging state by one request and return the expected response.
   function automatic lmwa_pkg::rsp_item_type predict_load_step(lmwa_pkg::req_item_type item);
      lmwa_pkg::rsp_item_type      result;
      int unsigned                 total;
      logic [lmwa_pkg::LOAD_W-1:0] level;
      result = '0;
      case (item.req_type)
         lmwa_pkg::REQ_RECORD: begin
            records_sent++;
            level = (item.sample > lmwa_pkg::LOAD_MAX) ?
                    lmwa_pkg::LOAD_W'(lmwa_pkg::LOAD_MAX) : item.sample;
            if (sample_fill < SAMPLE_SLOTS) begin
               sample_buf[sample_fill] = level;
               sample_fill++;
            end else begin
               result.sample_dropped = 1'b1;
               samples_dropped++;
            end
         end
         lmwa_pkg::REQ_TICK: begin
            ticks_sent++;
            total = 0;
            for (int i = 0; i < sample_fill; i++) total += sample_buf[i];
            one_min_avg = (sample_fill != 0) ? lmwa_pkg::LOAD_W'(total / sample_fill) : '0;
            sample_fill = 0;
            if (minute_fill < LONG_SPAN) begin
               minute_buf[minute_fill] = one_min_avg;
               minute_fill++;
            end
            // medium window first, then the long one from the same entries
            if (minute_fill >= MEDIUM_SPAN && minute_fill % MEDIUM_SPAN == 0) begin
               total = 0;
               for (int i = minute_fill - MEDIUM_SPAN; i < minute_fill; i++)
                  total += minute_buf[i];
               five_min_avg = lmwa_pkg::LOAD_W'(total / MEDIUM_SPAN);
               medium_closed++;
            end
            if (minute_fill >= LONG_SPAN) begin
               total = 0;
               for (int i = 0; i < LONG_SPAN; i++) total += minute_buf[i];
               thirty_min_avg = lmwa_pkg::LOAD_W'(total / LONG_SPAN);
               minute_fill    = 0;
               long_closed++;
            end
         end
         lmwa_pkg::REQ_CLEAR: begin
            clears_sent++;
            clear_load_history();
         end
         default: unused_sent++;
      endcase
      result.avg_short  = one_min_avg;
      result.avg_medium = five_min_avg;
      result.avg_long   = thirty_min_avg;
      return result;
   endfunction

   function automatic directed_row_type table_row(logic [1:0] code,
                                                  logic [lmwa_pkg::LOAD_W-1:0] level,
                                                  bit typed = 1'b0, int s_avg = 0,
                                                  int m_avg = 0, int l_avg = 0,
                                                  bit dropped = 1'b0);
      directed_row_type entry;
      entry.request.req_type      = code;
      entry.request.sample        = level;
      entry.typed                 = typed;
      entry.answer.avg_short      = lmwa_pkg::LOAD_W'(s_avg);
      entry.answer.avg_medium     = lmwa_pkg::LOAD_W'(m_avg);
      entry.answer.avg_long       = lmwa_pkg::LOAD_W'(l_avg);
      entry.answer.sample_dropped = dropped;
      return entry;
   endfunction

   function automatic logic [lmwa_pkg::LOAD_W-1:0] pick_load_sample();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return lmwa_pkg::LOAD_W'(lmwa_pkg::LOAD_MAX);
         2:       return '1;
         3:       return lmwa_pkg::LOAD_W'($urandom_range(lmwa_pkg::LOAD_MAX + 1, 1023));
         default: return lmwa_pkg::LOAD_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Mostly back-to-back or short gaps, a few long ones, and calm stretches.
   function automatic int unsigned pick_request_gap();
      int unsigned roll;
      if (calm_requests != 0) begin
         calm_requests--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm_requests = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void log_failure(string text);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, text);
   endfunction

   // Hold one request until accepted, then queue its expected response.
   task automatic issue_request(lmwa_pkg::req_item_type item, bit typed,
                                lmwa_pkg::rsp_item_type typed_answer);
      int unsigned            gap;
      lmwa_pkg::rsp_item_type predicted;
      gap = pick_request_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_load_step(item);
      expected_loads.push_back(typed ? typed_answer : predicted);
   endtask

   task automatic issue_random(logic [1:0] code);
      lmwa_pkg::req_item_type item;
      item.req_type = code;
      item.sample   = pick_load_sample();
      issue_request(item, 1'b0, '0);
   endtask

   // Response side back-pressure: short and long stalls, with calm stretches.
   always @(posedge clock) begin
      if (stall_hold == 0) begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 3) begin
            stall_hold = $urandom_range(100, 300);
            stall_now  = 1'b0;
         end else if (stall_roll < 40) begin
            stall_hold = $urandom_range(1, 3);
            stall_now  = 1'b1;
         end else if (stall_roll < 44) begin
            stall_hold = $urandom_range(10, 60);
            stall_now  = 1'b1;
         end else begin
            stall_hold = 1;
            stall_now  = 1'b0;
         end
      end
      stall_hold--;
      rsp_stall <= stall_now;
   end

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (expected_loads.size() == 0) begin
            log_failure($sformatf("response with nothing expected: %h", rsp_data));
         end else begin
            oldest_load = expected_loads.pop_front();
            if (rsp_data.avg_short !== oldest_load.avg_short)
               log_failure($sformatf("avg_short expected %0d got %0d",
                                     oldest_load.avg_short, rsp_data.avg_short));
            if (rsp_data.avg_medium !== oldest_load.avg_medium)
               log_failure($sformatf("avg_medium expected %0d got %0d",
                                     oldest_load.avg_medium, rsp_data.avg_medium));
            if (rsp_data.avg_long !== oldest_load.avg_long)
               log_failure($sformatf("avg_long expected %0d got %0d",
                                     oldest_load.avg_long, rsp_data.avg_long));
            if (rsp_data.sample_dropped !== oldest_load.sample_dropped)
               log_failure($sformatf("sample_dropped expected %0d got %0d",
                                     oldest_load.sample_dropped, rsp_data.sample_dropped));
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_loads.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      int unsigned random_sent;
      int unsigned burst;
      int unsigned roll;

      clear_load_history();

      // directed part: saturation, empty tick, unused code, full store, medium window, clear
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1023, 1'b1, 0, 0, 0, 1'b0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd0, 1'b1, 1000, 0, 0, 1'b0));
      directed_table.push_back(table_row(REQ_UNUSED, 10'd1023, 1'b1, 1000, 0, 0, 1'b0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd1023, 1'b1, 0, 0, 0, 1'b0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1000));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd512));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd999));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1001));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd341));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd682));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd7));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1000));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd250));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd750));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'd1023, 1'b1, 0, 0, 0, 1'b1));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_CLEAR, 10'd1023, 1'b1, 0, 0, 0, 1'b0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'h155));
      directed_table.push_back(table_row(lmwa_pkg::REQ_RECORD, 10'h2AA));
      directed_table.push_back(table_row(lmwa_pkg::REQ_TICK, 10'd0));
      directed_table.push_back(table_row(lmwa_pkg::REQ_CLEAR, 10'd0, 1'b1, 0, 0, 0, 1'b0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i])
         issue_request(directed_table[i].request, directed_table[i].typed,
                       directed_table[i].answer);

      // random part: mostly whole minutes of samples closed by a tick
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 2) begin
            issue_random(lmwa_pkg::REQ_CLEAR);
            random_sent++;
         end else if (roll < 5) begin
            issue_random(REQ_UNUSED);
         end else begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(SAMPLE_SLOTS, 15)
                                                : $urandom_range(0, SAMPLE_SLOTS);
            for (int n = 0; n < burst; n++) begin
               if ($urandom_range(0, 49) == 0) issue_random(REQ_UNUSED);
               issue_random(lmwa_pkg::REQ_RECORD);
            end
            issue_random(lmwa_pkg::REQ_TICK);
            random_sent += burst + 1;
         end
      end

      req_valid <= 1'b0;
      while (expected_loads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d records (%0d dropped), %0d ticks, %0d clears, %0d unused codes",
               records_sent, samples_dropped, ticks_sent, clears_sent, unused_sent);
      $display("Checked %0d responses over %0d five-minute and %0d thirty-minute windows",
               responses_seen, medium_closed, long_closed);
      if (mismatch_count == 0 && expected_loads.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/lmwa_pkg.sv
rtl/lmwa_ram.sv
rtl/lmwa_div.sv
rtl/load_multi_window_average.sv
verif/load_multi_window_average_tb.sv
